// File: src/lmts_pkg.sv
package lmts_pkg;

    // LCD modes as they appear on the mode output.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCROLL_X     = 2'd0;
    localparam logic [1:0] CFG_LINE_COMPARE = 2'd1;
    localparam logic [1:0] CFG_STAT_ENABLES = 2'd2;

    // Line timing in dots.
    localparam logic [8:0] OAM_DOTS       = 9'd80;
    localparam logic [8:0] XFER_BASE_DOTS = 9'd172;
    localparam logic [8:0] LINE_DOTS      = 9'd456;
    localparam logic [8:0] DOTS_PER_TICK  = 9'd4;

    // Line numbers and screen width.
    localparam logic [7:0] VBLANK_FIRST = 8'd144;
    localparam logic [7:0] LAST_LINE    = 8'd153;
    localparam logic [7:0] SCREEN_W     = 8'd160;
    localparam logic [7:0] PIX_PER_TICK = 8'd4;

    // One result beat.
    typedef struct packed {
        logic [1:0] lcd_mode;
        logic [7:0] current_line;
        logic [7:0] render_x_start;
        logic [2:0] render_count;
        logic       coincidence;
        logic       stat_irq;
    } t_result;

endpackage

// File: src/lcd_mode_timing_stat_irq.sv
// LCD mode sequencer with STAT interrupt request generation.
// A result beat is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one tick beat per cycle while o_stall is low; the sequencer state is registered on each accepted beat.
// A two-entry output register (main plus skid) keeps input and output apart.
// Reset (synchronous, active low): OAM scan, line 0, dot 0, registers cleared,
// output empty.
module lcd_mode_timing_stat_irq (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_tick_valid,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_lcd_mode,
    output logic [7:0] o_current_line,
    output logic [7:0] o_render_x_start,
    output logic [2:0] o_render_count,
    output logic       o_coincidence,
    output logic       o_stat_irq
);

    // Configuration registers.
    logic [7:0] r_scroll_x;
    logic [7:0] r_line_compare;
    logic [3:0] r_stat_enables;

    // Sequencer state.
    logic [1:0] r_mode, n_mode;
    logic [8:0] r_dot, n_dot;
    logic [7:0] r_line, n_line;
    logic [7:0] r_pixel_x, n_pixel_x;
    logic       r_level, n_level;
    logic       r_coin, n_coin;

    // Output stage.
    logic                  r_out_valid;
    logic                  r_skid_valid;
    lmts_pkg::t_result     r_out;
    lmts_pkg::t_result     r_skid;
    lmts_pkg::t_result     n_result;

    logic       in_acc;
    logic       out_take;
    logic       upd;
    logic       match;
    logic       lvl;
    logic [8:0] dot_inc;
    logic [8:0] xfer_end;
    logic [7:0] px_left;
    logic [7:0] px_cnt;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x     <= 8'd0;
            r_line_compare <= 8'd0;
            r_stat_enables <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lmts_pkg::CFG_SCROLL_X:     r_scroll_x     <= i_cfg_data;
                lmts_pkg::CFG_LINE_COMPARE: r_line_compare <= i_cfg_data;
                lmts_pkg::CFG_STAT_ENABLES: r_stat_enables <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Next state of the sequencer for one tick.
    always_comb begin
        dot_inc   = r_dot + lmts_pkg::DOTS_PER_TICK;
        xfer_end  = lmts_pkg::OAM_DOTS + lmts_pkg::XFER_BASE_DOTS
                    + {6'd0, r_scroll_x[2:0]};
        px_left   = lmts_pkg::SCREEN_W - r_pixel_x;
        px_cnt    = 8'd0;
        n_mode    = r_mode;
        n_dot     = r_dot;
        n_line    = r_line;
        n_pixel_x = r_pixel_x;
        upd       = 1'b0;
        n_result.render_x_start = r_pixel_x;

        if (i_tick_valid) begin
            n_dot = dot_inc;
            case (r_mode)
                lmts_pkg::MODE_OAM: begin
                    if (dot_inc >= lmts_pkg::OAM_DOTS) begin
                        n_mode    = lmts_pkg::MODE_XFER;
                        n_pixel_x = 8'd0;
                        n_result.render_x_start = 8'd0;
                        upd       = 1'b1;
                    end
                end
                lmts_pkg::MODE_XFER: begin
                    // Up to four pixels a tick until the line is full.
                    if (r_pixel_x < lmts_pkg::SCREEN_W) begin
                        px_cnt = (px_left > lmts_pkg::PIX_PER_TICK)
                                 ? lmts_pkg::PIX_PER_TICK : px_left;
                        n_pixel_x = r_pixel_x + px_cnt;
                    end
                    if (dot_inc >= xfer_end) begin
                        n_mode = lmts_pkg::MODE_HBLANK;
                        upd    = 1'b1;
                    end
                end
                lmts_pkg::MODE_HBLANK: begin
                    if (dot_inc >= lmts_pkg::LINE_DOTS) begin
                        n_dot  = dot_inc - lmts_pkg::LINE_DOTS;
                        n_line = r_line + 8'd1;
                        n_mode = (n_line == lmts_pkg::VBLANK_FIRST)
                                 ? lmts_pkg::MODE_VBLANK : lmts_pkg::MODE_OAM;
                        upd    = 1'b1;
                    end
                end
                default: begin
                    // Vertical blank: wrap to line 0 after the last line.
                    if (dot_inc >= lmts_pkg::LINE_DOTS) begin
                        n_dot  = dot_inc - lmts_pkg::LINE_DOTS;
                        n_line = r_line + 8'd1;
                        if (n_line > lmts_pkg::LAST_LINE) begin
                            n_line = 8'd0;
                            n_mode = lmts_pkg::MODE_OAM;
                        end
                        upd    = 1'b1;
                    end
                end
            endcase
        end

        // STAT level and coincidence, refreshed only on a mode or line change.
        match = (n_line == r_line_compare);
        lvl   = (r_stat_enables[0] && (n_mode == lmts_pkg::MODE_HBLANK))
             || (r_stat_enables[1] && (n_mode == lmts_pkg::MODE_VBLANK))
             || (r_stat_enables[2] && (n_mode == lmts_pkg::MODE_OAM))
             || (r_stat_enables[3] && match);
        n_coin  = upd ? match : r_coin;
        n_level = upd ? lvl : r_level;

        n_result.lcd_mode     = n_mode;
        n_result.current_line = n_line;
        n_result.render_count = px_cnt[2:0];
        n_result.coincidence  = n_coin;
        n_result.stat_irq     = upd && lvl && !r_level;
    end

    // State registers advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= lmts_pkg::MODE_OAM;
            r_dot     <= 9'd0;
            r_line    <= 8'd0;
            r_pixel_x <= 8'd0;
            r_level   <= 1'b0;
            r_coin    <= 1'b0;
        end else if (in_acc) begin
            r_mode    <= n_mode;
            r_dot     <= n_dot;
            r_line    <= n_line;
            r_pixel_x <= n_pixel_x;
            r_level   <= n_level;
            r_coin    <= n_coin;
        end
    end

    // Output register with a skid entry for beats that arrive under stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_result;
            end
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_lcd_mode       = r_out.lcd_mode;
    assign o_current_line   = r_out.current_line;
    assign o_render_x_start = r_out.render_x_start;
    assign o_render_count   = r_out.render_count;
    assign o_coincidence    = r_out.coincidence;
    assign o_stat_irq       = r_out.stat_irq;

endmodule

// File: src/lmts_chk.sv
module lmts_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_lcd_mode,
    input logic [7:0] o_current_line,
    input logic [2:0] o_render_count,
    input logic       o_stat_irq
);

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    // Pixels are only rendered during pixel transfer.
    a_render_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_render_count != 3'd0) |-> o_lcd_mode == lmts_pkg::MODE_XFER)
        else $error("pixels rendered outside pixel transfer");

    // Vertical blank only on the blank lines.
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_lcd_mode == lmts_pkg::MODE_VBLANK)
        |-> o_current_line >= lmts_pkg::VBLANK_FIRST)
        else $error("vertical blank on a visible line");

    // Line number never passes the last line.
    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_current_line <= lmts_pkg::LAST_LINE)
        else $error("line number out of range");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lcd_mode)
            && $stable(o_current_line) && $stable(o_stat_irq))
        else $error("stalled result beat changed");

endmodule

bind lcd_mode_timing_stat_irq lmts_chk u_lmts_chk (.*);

// File: tb/sv/tb_top.sv
module tb_top;

    // Index 3 is not a register; writes to it must leave the sequencer alone.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_PHASES   = 9;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [1:0] i_cfg_index  = lmts_pkg::CFG_SCROLL_X;
    logic [7:0] i_cfg_data   = 8'd0;
    logic       i_valid      = 1'b0;
    logic       i_tick_valid = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_lcd_mode;
    logic [7:0] o_current_line;
    logic [7:0] o_render_x_start;
    logic [2:0] o_render_count;
    logic       o_coincidence;
    logic       o_stat_irq;

    lcd_mode_timing_stat_irq dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_tick_valid     (i_tick_valid),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_lcd_mode       (o_lcd_mode),
        .o_current_line   (o_current_line),
        .o_render_x_start (o_render_x_start),
        .o_render_count   (o_render_count),
        .o_coincidence    (o_coincidence),
        .o_stat_irq       (o_stat_irq)
    );

    always #1 i_clk = ~i_clk;

    // Register copies used for prediction.
    logic [7:0] cfg_scroll_x = 8'd0;
    logic [7:0] cfg_line_cmp = 8'd0;
    logic [3:0] cfg_stat_en  = 4'd0;

    // Sequencer state as predicted, starting from the reset values.
    logic [1:0] seq_mode     = lmts_pkg::MODE_OAM;
    logic [8:0] seq_dots     = 9'd0;
    logic [7:0] seq_line     = 8'd0;
    logic [7:0] seq_pix_x    = 8'd0;
    logic       seq_stat_lvl = 1'b0;
    logic       seq_coin     = 1'b0;

    lmts_pkg::t_result lcd_status_q[$];
    logic    pending_ticks[$];
    int      ticks_left    = 0;
    int      errors        = 0;
    int      send_gap      = 0;
    int      recv_gap      = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      quiet_cycles  = 0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want_val);
        if (got != want_val) begin
            report_error($sformatf("%s is %0d, expected %0d", name, got, want_val));
        end
    endtask

    // Recompute the coincidence flag and the combined STAT level; true on a rising edge.
    function automatic logic refresh_stat();
        logic hit;
        logic lvl;
        logic rise;
        hit = (seq_line == cfg_line_cmp);
        seq_coin = hit;
        lvl = (cfg_stat_en[0] && seq_mode == lmts_pkg::MODE_HBLANK) ||
              (cfg_stat_en[1] && seq_mode == lmts_pkg::MODE_VBLANK) ||
              (cfg_stat_en[2] && seq_mode == lmts_pkg::MODE_OAM) ||
              (cfg_stat_en[3] && hit);
        rise = lvl && !seq_stat_lvl;
        seq_stat_lvl = lvl;
        return rise;
    endfunction

    // Advance the sequencer by one beat and return the status it should report.
    function automatic lmts_pkg::t_result advance_lcd_timing(input logic tick);
        lmts_pkg::t_result r;
        logic [7:0] xstart;
        logic [7:0] count;
        logic [8:0] xfer_end;
        logic       irq;
        xstart = seq_pix_x;
        count  = 8'd0;
        irq    = 1'b0;
        if (tick) begin
            seq_dots = seq_dots + lmts_pkg::DOTS_PER_TICK;
            case (seq_mode)
                lmts_pkg::MODE_OAM: begin
                    if (seq_dots >= lmts_pkg::OAM_DOTS) begin
                        seq_mode  = lmts_pkg::MODE_XFER;
                        seq_pix_x = 8'd0;
                        xstart    = 8'd0;
                        irq       = refresh_stat();
                    end
                end
                lmts_pkg::MODE_XFER: begin
                    // Scroll adds its fine part to the transfer length.
                    xfer_end = lmts_pkg::OAM_DOTS + lmts_pkg::XFER_BASE_DOTS
                               + {6'd0, cfg_scroll_x[2:0]};
                    if (seq_pix_x < lmts_pkg::SCREEN_W) begin
                        count = lmts_pkg::SCREEN_W - seq_pix_x;
                        if (count > lmts_pkg::PIX_PER_TICK) begin
                            count = lmts_pkg::PIX_PER_TICK;
                        end
                        seq_pix_x = seq_pix_x + count;
                    end
                    if (seq_dots >= xfer_end) begin
                        seq_mode = lmts_pkg::MODE_HBLANK;
                        irq      = refresh_stat();
                    end
                end
                lmts_pkg::MODE_HBLANK: begin
                    if (seq_dots >= lmts_pkg::LINE_DOTS) begin
                        seq_dots = seq_dots - lmts_pkg::LINE_DOTS;
                        seq_line = seq_line + 8'd1;
                        seq_mode = (seq_line == lmts_pkg::VBLANK_FIRST)
                                   ? lmts_pkg::MODE_VBLANK : lmts_pkg::MODE_OAM;
                        irq      = refresh_stat();
                    end
                end
                default: begin
                    // Vertical blanking runs to the last line, then the frame wraps.
                    if (seq_dots >= lmts_pkg::LINE_DOTS) begin
                        seq_dots = seq_dots - lmts_pkg::LINE_DOTS;
                        seq_line = seq_line + 8'd1;
                        if (seq_line > lmts_pkg::LAST_LINE) begin
                            seq_line = 8'd0;
                            seq_mode = lmts_pkg::MODE_OAM;
                        end
                        irq = refresh_stat();
                    end
                end
            endcase
        end
        r.lcd_mode       = seq_mode;
        r.current_line   = seq_line;
        r.render_x_start = xstart;
        r.render_count   = count[2:0];
        r.coincidence    = seq_coin;
        r.stat_irq       = irq;
        return r;
    endfunction

    // Tick driver: predicts each accepted beat and inserts random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                lcd_status_q.push_back(advance_lcd_timing(i_tick_valid));
                ticks_left--;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_ticks.size() == 0) begin
                    i_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 10);
                    i_valid <= 1'b0;
                end else begin
                    i_valid      <= 1'b1;
                    i_tick_valid <= pending_ticks.pop_front();
                end
            end
        end
    end

    // Status monitor: compares each accepted beat with the oldest prediction.
    always @(posedge i_clk) begin
        lmts_pkg::t_result seen;
        lmts_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                seen = '{o_lcd_mode, o_current_line, o_render_x_start, o_render_count,
                         o_coincidence, o_stat_irq};
                if (lcd_status_q.size() == 0) begin
                    report_error($sformatf("status beat with no tick outstanding (line %0d)",
                                           seen.current_line));
                end else begin
                    want = lcd_status_q.pop_front();
                    check_field("lcd_mode", int'(seen.lcd_mode), int'(want.lcd_mode));
                    check_field("current_line", int'(seen.current_line),
                                int'(want.current_line));
                    check_field("render_x_start", int'(seen.render_x_start),
                                int'(want.render_x_start));
                    check_field("render_count", int'(seen.render_count),
                                int'(want.render_count));
                    check_field("coincidence", int'(seen.coincidence),
                                int'(want.coincidence));
                    check_field("stat_irq", int'(seen.stat_irq), int'(want.stat_irq));
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                recv_gap = $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any beat or register write.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_tick(input logic tick);
        pending_ticks.push_back(tick);
        ticks_left++;
    endtask

    // Write one register; only called while the sequencer has nothing in flight.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lmts_pkg::CFG_SCROLL_X:     cfg_scroll_x = val;
            lmts_pkg::CFG_LINE_COMPARE: cfg_line_cmp = val;
            lmts_pkg::CFG_STAT_ENABLES: cfg_stat_en  = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (ticks_left != 0 || lcd_status_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int n_ticks;
        int tick_pct;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle ticks right after reset: line 0 equals the compare value, yet the
        // coincidence flag must stay low until the first mode change.
        queue_tick(1'b0);
        queue_tick(1'b0);
        wait_idle();

        // Longest transfer, all sources enabled: the entry into pixel transfer
        // sets coincidence and raises the interrupt, then pixels start at x 0.
        write_reg(lmts_pkg::CFG_SCROLL_X, 8'd7);
        write_reg(lmts_pkg::CFG_LINE_COMPARE, 8'd0);
        write_reg(lmts_pkg::CFG_STAT_ENABLES, 8'h0F);
        repeat (22) queue_tick(1'b1);
        wait_idle();

        // Random phases of under a line each, under changing register settings.
        // The compare value mostly stays on the first few lines so that
        // coincidence is actually reached.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(lmts_pkg::CFG_SCROLL_X, 8'hFF);
                    write_reg(lmts_pkg::CFG_LINE_COMPARE, 8'hFF);
                    write_reg(lmts_pkg::CFG_STAT_ENABLES, 8'hF0);
                    write_reg(CFG_UNUSED, 8'($urandom));
                end
                1: begin
                    write_reg(lmts_pkg::CFG_SCROLL_X, 8'h00);
                    write_reg(lmts_pkg::CFG_LINE_COMPARE, lmts_pkg::LAST_LINE);
                    write_reg(lmts_pkg::CFG_STAT_ENABLES, 8'h0F);
                end
                2: begin
                    write_reg(lmts_pkg::CFG_SCROLL_X, 8'hF8);
                    write_reg(lmts_pkg::CFG_LINE_COMPARE, lmts_pkg::VBLANK_FIRST);
                    write_reg(lmts_pkg::CFG_STAT_ENABLES, 8'h03);
                end
                default: begin
                    write_reg(lmts_pkg::CFG_SCROLL_X, 8'($urandom));
                    write_reg(lmts_pkg::CFG_LINE_COMPARE, ($urandom_range(0, 7) == 0) ?
                              8'($urandom) : 8'($urandom_range(0, 7)));
                    write_reg(lmts_pkg::CFG_STAT_ENABLES, 8'($urandom));
                end
            endcase
            if (p == NUM_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 15 * $urandom_range(0, 3);
                recv_idle_pct = 15 * $urandom_range(0, 3);
            end
            n_ticks  = $urandom_range(80, 100);
            tick_pct = (p % 3 == 2) ? 50 : 95;
            repeat (n_ticks) queue_tick($urandom_range(0, 99) < tick_pct);
            wait_idle();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
